// File: hw/rtl/bms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 8;
  localparam int DECAY_BITS     = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int ROOT_STEPS     = 32;
  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SPEED   = 3'd0,
    REG_MIN_SPEED   = 3'd1,
    REG_DECAY       = 3'd2,
    REG_BODY_LENGTH = 3'd3,
    REG_CENTER_X    = 3'd4,
    REG_CENTER_Y    = 3'd5,
    REG_CENTER_Z    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [7:0]         neighbor_count;
    logic               flatten;
    logic               pull_to_center;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tail_x;
    logic signed [31:0] tail_y;
    logic signed [31:0] tail_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } out_word_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_DIFF, OP_DSQ, OP_ACC, OP_SQRT, OP_PKM, OP_PK,
    OP_PDIV, OP_PNKM, OP_PVEL, OP_CNTM, OP_CRDIFF, OP_CRM, OP_CROWD,
    OP_FRM, OP_FEAR, OP_ADDACC, OP_VSQ, OP_VDIV, OP_DIR, OP_MAXS,
    OP_MXM, OP_MXC, OP_MNM, OP_MNC, OP_CLM, OP_CLS, OP_FSM, OP_FSS,
    OP_POS, OP_TLM, OP_TLS, OP_DCM, OP_DCS, OP_OUT
  } dp_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DIFF, S_DSQ, S_DACC, S_DSQRT, S_DWAIT, S_PCHK, S_PK,
    S_PDIV, S_PDWAIT, S_PNK, S_PVEL, S_CNT, S_CRDIFF, S_CRM, S_CROWD,
    S_FRM, S_FEAR, S_ADDACC, S_VSQ, S_VACC, S_VSQRT, S_VWAIT, S_VDIV,
    S_VDWAIT, S_DIR, S_MAXS, S_MXM, S_MXC, S_MNM, S_MNC, S_CLB, S_CLM,
    S_CLS, S_FSM, S_FSS, S_POS, S_TLM, S_TLS, S_DCM, S_DCS, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic pull;
    logic far;
    logic sqrt_busy;
    logic div_busy;
    logic clamp;
  } dp_status_t;

  // fixed point constants, rounded to nearest
  function automatic longint c_0_02(input int f);
    return ((longint'(2) << f) + 50) / 100;
  endfunction

  function automatic longint c_0_1(input int f);
    return ((longint'(1) << f) + 5) / 10;
  endfunction

  function automatic longint c_0_2(input int f);
    return ((longint'(2) << f) + 5) / 10;
  endfunction

  function automatic longint c_pull(input int f);
    return ((longint'(25) << f) + 50000) / 100000;
  endfunction

  function automatic longint c_thresh(input int f);
    return longint'(200) << f;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -70'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/boid_motion_step.sv
// Motion update for one flocking agent, one frame tick per input word.
// item channel: item_valid / item_stall / item carries acceleration,
// neighbor count, flatten and pull-to-center flags. result channel:
// result_valid / result_stall / result carries new position, tail point
// and decayed velocity. A word moves when valid is high and stall is low.
// Config: cfg_we writes cfg_data into register cfg_index (0 max_speed,
// 1 min_speed, 2 decay, 3 body_length, 4..6 center); other indexes ignored.
// Extra steps run when the speed clamp applies, when the center pull is
// requested and when the agent is also far enough to be pulled. The work
// is done by the bit-serial square root and the restoring divider that
// normalize the direction, plus one shared multiplier used one product a
// cycle. One word is in flight at a time; item_stall drops when idle.
// Reset clears position and velocity, sets crowd and fear to 1.0 and the
// registers to their defaults. A result waiting under result_stall sits in
// the output register; the next word is accepted and worked on meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module boid_motion_step #(
  parameter int FRAC_BITS  = bms_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = bms_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire bms_pkg::in_word_t               item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output bms_pkg::out_word_t                   result,
  input  wire logic                            cfg_we,
  input  wire logic [bms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bms_pkg::dp_cmd_t    cmd;
  bms_pkg::dp_status_t status;

  bms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  bms_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("accepted a word but did not start work");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.sqrt_busy && status.div_busy))
    else $error("sqrt and divider busy together");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !status.sqrt_busy && !status.div_busy)
    else $error("iterative unit running while idle");

endmodule

`default_nettype wire

// File: hw/rtl/bms_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// floor square root, one result bit per cycle
module bms_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             busy,
  output logic [31:0]      root
);

  logic [63:0] v, r, b;
  logic [4:0]  cnt;
  logic [63:0] trial;

  assign trial = r + b;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'(bms_pkg::ROOT_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= radicand;
      r <= '0;
      b <= 64'd1 << 62;
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bms_div.sv
`timescale 1ns / 1ps
`default_nettype none

// num * 2^FRAC_BITS / den, truncated toward zero; |num| <= den
module bms_div #(
  parameter int FRAC_BITS = bms_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [31:0]      num,
  input  wire logic [31:0]             den,
  output logic                         busy,
  output logic signed [FRAC_BITS+1:0]  quo
);

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(QW);

  logic [33:0]   rem;
  logic [31:0]   den_r;
  logic [QW-1:0] q;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          ge;
  logic [33:0]   rem_sub;
  logic [31:0]   mag;

  assign mag     = num[31] ? 32'(-num) : 32'(num);
  assign ge      = rem >= 34'(den_r);
  assign rem_sub = ge ? rem - 34'(den_r) : rem;
  assign quo     = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(QW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= 34'(mag);
      den_r <= den;
      q     <= '0;
      neg   <= num[31];
    end else if (busy) begin
      q   <= {q[QW-2:0], ge};
      rem <= {rem_sub[32:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bms_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bms_datapath #(
  parameter int FRAC_BITS  = bms_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = bms_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bms_pkg::dp_cmd_t                  cmd,
  output bms_pkg::dp_status_t                    status,
  input  wire bms_pkg::in_word_t                 item,
  output bms_pkg::out_word_t                     result,
  input  wire logic                              cfg_we,
  input  wire logic [bms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bms_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int F   = FRAC_BITS;
  localparam int CB  = (COUNT_BITS > 8) ? 8 : COUNT_BITS;
  localparam int MSW = ((21 > F + 1) ? 21 : F + 1) + 1;
  localparam logic [7:0] CNT_MASK = 8'((1 << CB) - 1);
  localparam longint ONE_L   = longint'(1) << F;
  localparam longint HALF_L  = ONE_L >> 1;
  localparam longint DSAT_L  = longint'(1) << (F + 5);
  localparam longint C002_L  = bms_pkg::c_0_02(F);
  localparam longint C01_L   = bms_pkg::c_0_1(F);
  localparam longint C02_L   = bms_pkg::c_0_2(F);
  localparam longint CPULL_L = bms_pkg::c_pull(F);
  localparam longint TH_L    = bms_pkg::c_thresh(F);

  // configuration
  logic [20:0]        max_speed, min_speed;
  logic [15:0]        decay;
  logic [22:0]        body_length;
  logic signed [31:0] center [3];

  // agent state
  logic [31:0]        pos [3];
  logic signed [31:0] vel [3];
  logic [F:0]         crowd, fear;

  // latched item
  logic signed [31:0] acc [3];
  logic [7:0]         cnt;
  logic               flat, pull;

  // working registers
  logic signed [31:0]  d [3];
  logic signed [F+1:0] dir [3];
  logic [31:0]         tail [3];
  logic signed [33:0]  k, tmp;
  logic [MSW-1:0]      maxs;
  logic [63:0]         sq;
  logic signed [67:0]  prod, prod_sh;
  logic                gtmax, ltmin;

  logic signed [33:0]  mul_a, mul_b;
  logic signed [69:0]  dw, cw;
  logic [31:0]         len;
  logic                sqrt_busy, div_busy, div_start;
  logic signed [31:0]  div_num;
  logic signed [F+1:0] div_quo;
  logic [1:0]          ix;

  assign ix = cmd.idx;

  bms_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == bms_pkg::OP_SQRT),
    .radicand (sq),
    .busy     (sqrt_busy),
    .root     (len)
  );

  assign div_start = (cmd.op == bms_pkg::OP_PDIV) || (cmd.op == bms_pkg::OP_VDIV);
  assign div_num   = (cmd.op == bms_pkg::OP_PDIV) ? d[ix] : vel[ix];

  bms_div #(.FRAC_BITS(F)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (len),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign status.pull      = pull;
  assign status.far       = 34'(len) > 34'(TH_L);
  assign status.sqrt_busy = sqrt_busy;
  assign status.div_busy  = div_busy;
  assign status.clamp     = gtmax | ltmin;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      bms_pkg::OP_DSQ:  begin mul_a = 34'(d[ix]);   mul_b = 34'(d[ix]); end
      bms_pkg::OP_PKM:  begin mul_a = 34'(len) - 34'(TH_L); mul_b = 34'(CPULL_L); end
      bms_pkg::OP_PNKM: begin mul_a = 34'(div_quo); mul_b = k; end
      bms_pkg::OP_CNTM: begin mul_a = 34'(cnt & CNT_MASK); mul_b = 34'(C002_L); end
      bms_pkg::OP_CRM:  begin mul_a = tmp;          mul_b = 34'(C01_L); end
      bms_pkg::OP_FRM:  begin mul_a = 34'(fear);    mul_b = 34'(C02_L); end
      bms_pkg::OP_VSQ:  begin mul_a = 34'(vel[ix]); mul_b = 34'(vel[ix]); end
      bms_pkg::OP_MXM:  begin mul_a = 34'(maxs);    mul_b = 34'(maxs); end
      bms_pkg::OP_MNM:  begin mul_a = 34'(min_speed); mul_b = 34'(min_speed); end
      bms_pkg::OP_CLM:  begin
        mul_a = 34'(dir[ix]);
        mul_b = gtmax ? 34'(maxs) : 34'(min_speed);
      end
      bms_pkg::OP_FSM:  begin mul_a = 34'(vel[ix]); mul_b = 34'(ONE_L) + 34'(fear); end
      bms_pkg::OP_TLM:  begin mul_a = 34'(dir[ix]); mul_b = 34'(body_length); end
      bms_pkg::OP_DCM:  begin mul_a = 34'(vel[ix]); mul_b = 34'(decay); end
      default: ;
    endcase
  end

  assign prod_sh = prod >>> F;
  // crowd minus target; large values all clamp to the floor anyway
  assign dw = 70'(crowd) - 70'(ONE_L) + 70'(prod);
  assign cw = 70'(crowd) - 70'(prod_sh);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed   <= 21'(longint'(13) << (F - 2));
      min_speed   <= 21'(longint'(5) << (F - 2));
      decay       <= 16'd64881;
      body_length <= 23'(longint'(5) << F);
      for (int i = 0; i < 3; i++) begin
        center[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (bms_pkg::cfg_reg_t'(cfg_index))
        bms_pkg::REG_MAX_SPEED:   max_speed   <= cfg_data[20:0];
        bms_pkg::REG_MIN_SPEED:   min_speed   <= cfg_data[20:0];
        bms_pkg::REG_DECAY:       decay       <= cfg_data[15:0];
        bms_pkg::REG_BODY_LENGTH: body_length <= cfg_data[22:0];
        bms_pkg::REG_CENTER_X:    center[0]   <= cfg_data;
        bms_pkg::REG_CENTER_Y:    center[1]   <= cfg_data;
        bms_pkg::REG_CENTER_Z:    center[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // agent state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
      crowd <= (F+1)'(ONE_L);
      fear  <= (F+1)'(ONE_L);
    end else begin
      unique case (cmd.op)
        bms_pkg::OP_PVEL:
          vel[ix] <= bms_pkg::sat32(70'(vel[ix]) - 70'(prod_sh));
        bms_pkg::OP_CROWD: begin
          if (cw < 70'(HALF_L)) begin
            crowd <= (F+1)'(HALF_L);
          end else if (cw > 70'(ONE_L)) begin
            crowd <= (F+1)'(ONE_L);
          end else begin
            crowd <= cw[F:0];
          end
        end
        bms_pkg::OP_FEAR:
          fear <= fear - prod_sh[F:0];
        bms_pkg::OP_ADDACC: begin
          vel[0] <= bms_pkg::sat32(70'(vel[0]) + 70'(acc[0]));
          vel[1] <= bms_pkg::sat32(70'(vel[1]) + 70'(acc[1]));
          vel[2] <= bms_pkg::sat32(70'(vel[2]) + (flat ? 70'sd0 : 70'(acc[2])));
        end
        bms_pkg::OP_CLS:
          vel[ix] <= prod_sh[31:0];
        bms_pkg::OP_FSS:
          vel[ix] <= bms_pkg::sat32(70'(prod_sh));
        bms_pkg::OP_POS: begin
          pos[0] <= pos[0] + vel[0];
          pos[1] <= pos[1] + vel[1];
          pos[2] <= flat ? 32'd0 : pos[2] + vel[2];
        end
        bms_pkg::OP_DCS:
          vel[ix] <= bms_pkg::sat32(70'(prod >>> bms_pkg::DECAY_BITS));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pull <= 1'b0;
    end else if (cmd.op == bms_pkg::OP_LOAD) begin
      pull <= item.pull_to_center;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bms_pkg::OP_LOAD: begin
        acc[0] <= item.acc_x;
        acc[1] <= item.acc_y;
        acc[2] <= item.acc_z;
        cnt    <= item.neighbor_count;
        flat   <= item.flatten;
      end
      bms_pkg::OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          d[i] <= bms_pkg::sat32(70'($signed(pos[i])) - 70'(center[i]));
        end
        sq <= '0;
      end
      bms_pkg::OP_ACC:    sq <= sq + prod[63:0];
      bms_pkg::OP_ADDACC: sq <= '0;
      bms_pkg::OP_PK:     k <= prod_sh[33:0];
      bms_pkg::OP_CRDIFF: tmp <= (dw > 70'(DSAT_L)) ? 34'(DSAT_L) : dw[33:0];
      bms_pkg::OP_DIR:    dir[ix] <= (len == '0) ? '0 : div_quo;
      bms_pkg::OP_MAXS:   maxs <= MSW'(max_speed) + MSW'(crowd);
      bms_pkg::OP_MXC:    gtmax <= sq > prod[63:0];
      bms_pkg::OP_MNC:    ltmin <= sq < prod[63:0];
      bms_pkg::OP_TLS:    tail[ix] <= pos[ix] - prod_sh[31:0];
      bms_pkg::OP_OUT: begin
        result.pos_x  <= pos[0];
        result.pos_y  <= pos[1];
        result.pos_z  <= pos[2];
        result.tail_x <= tail[0];
        result.tail_y <= tail[1];
        result.tail_z <= tail[2];
        result.vel_x  <= vel[0];
        result.vel_y  <= vel[1];
        result.vel_z  <= vel[2];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/bms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output bms_pkg::dp_cmd_t         cmd,
  input  wire bms_pkg::dp_status_t status
);

  bms_pkg::ctrl_state_t state, state_next;
  logic [1:0] idx, idx_next;
  logic       slot_free;
  logic       last;

  assign slot_free = !result_valid || !result_stall;
  assign last      = (idx == bms_pkg::LAST_AXIS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bms_pkg::S_IDLE;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (state == bms_pkg::S_OUT && slot_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // per-axis loops leave idx at zero on exit
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      bms_pkg::S_IDLE:   if (item_valid) state_next = bms_pkg::S_DIFF;
      bms_pkg::S_DIFF:   state_next = status.pull ? bms_pkg::S_DSQ : bms_pkg::S_CNT;
      bms_pkg::S_DSQ:    state_next = bms_pkg::S_DACC;
      bms_pkg::S_DACC: begin
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? bms_pkg::S_DSQRT : bms_pkg::S_DSQ;
      end
      bms_pkg::S_DSQRT:  state_next = bms_pkg::S_DWAIT;
      bms_pkg::S_DWAIT:  if (!status.sqrt_busy) state_next = bms_pkg::S_PCHK;
      bms_pkg::S_PCHK:   state_next = status.far ? bms_pkg::S_PK : bms_pkg::S_CNT;
      bms_pkg::S_PK:     state_next = bms_pkg::S_PDIV;
      bms_pkg::S_PDIV:   state_next = bms_pkg::S_PDWAIT;
      bms_pkg::S_PDWAIT: if (!status.div_busy) state_next = bms_pkg::S_PNK;
      bms_pkg::S_PNK:    state_next = bms_pkg::S_PVEL;
      bms_pkg::S_PVEL: begin
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? bms_pkg::S_CNT : bms_pkg::S_PDIV;
      end
      bms_pkg::S_CNT:    state_next = bms_pkg::S_CRDIFF;
      bms_pkg::S_CRDIFF: state_next = bms_pkg::S_CRM;
      bms_pkg::S_CRM:    state_next = bms_pkg::S_CROWD;
      bms_pkg::S_CROWD:  state_next = bms_pkg::S_FRM;
      bms_pkg::S_FRM:    state_next = bms_pkg::S_FEAR;
      bms_pkg::S_FEAR:   state_next = bms_pkg::S_ADDACC;
      bms_pkg::S_ADDACC: state_next = bms_pkg::S_VSQ;
      bms_pkg::S_VSQ:    state_next = bms_pkg::S_VACC;
      bms_pkg::S_VACC: begin
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? bms_pkg::S_VSQRT : bms_pkg::S_VSQ;
      end
      bms_pkg::S_VSQRT:  state_next = bms_pkg::S_VWAIT;
      bms_pkg::S_VWAIT:  if (!status.sqrt_busy) state_next = bms_pkg::S_VDIV;
      bms_pkg::S_VDIV:   state_next = bms_pkg::S_VDWAIT;
      bms_pkg::S_VDWAIT: if (!status.div_busy) state_next = bms_pkg::S_DIR;
      bms_pkg::S_DIR: begin
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? bms_pkg::S_MAXS : bms_pkg::S_VDIV;
      end
      bms_pkg::S_MAXS:   state_next = bms_pkg::S_MXM;
      bms_pkg::S_MXM:    state_next = bms_pkg::S_MXC;
      bms_pkg::S_MXC:    state_next = bms_pkg::S_MNM;
      bms_pkg::S_MNM:    state_next = bms_pkg::S_MNC;
      bms_pkg::S_MNC:    state_next = bms_pkg::S_CLB;
      bms_pkg::S_CLB:    state_next = status.clamp ? bms_pkg::S_CLM : bms_pkg::S_FSM;
      bms_pkg::S_CLM:    state_next = bms_pkg::S_CLS;
      bms_pkg::S_CLS: begin
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? bms_pkg::S_FSM : bms_pkg::S_CLM;
      end
      bms_pkg::S_FSM:    state_next = bms_pkg::S_FSS;
      bms_pkg::S_FSS: begin
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? bms_pkg::S_POS : bms_pkg::S_FSM;
      end
      bms_pkg::S_POS:    state_next = bms_pkg::S_TLM;
      bms_pkg::S_TLM:    state_next = bms_pkg::S_TLS;
      bms_pkg::S_TLS: begin
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? bms_pkg::S_DCM : bms_pkg::S_TLM;
      end
      bms_pkg::S_DCM:    state_next = bms_pkg::S_DCS;
      bms_pkg::S_DCS: begin
        idx_next   = last ? 2'd0 : idx + 2'd1;
        state_next = last ? bms_pkg::S_OUT : bms_pkg::S_DCM;
      end
      bms_pkg::S_OUT:    if (slot_free) state_next = bms_pkg::S_IDLE;
      default:           state_next = bms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != bms_pkg::S_IDLE);
    cmd.idx    = idx;
    cmd.op     = bms_pkg::OP_NONE;
    unique case (state)
      bms_pkg::S_IDLE:   if (item_valid) cmd.op = bms_pkg::OP_LOAD;
      bms_pkg::S_DIFF:   cmd.op = bms_pkg::OP_DIFF;
      bms_pkg::S_DSQ:    cmd.op = bms_pkg::OP_DSQ;
      bms_pkg::S_DACC:   cmd.op = bms_pkg::OP_ACC;
      bms_pkg::S_DSQRT:  cmd.op = bms_pkg::OP_SQRT;
      bms_pkg::S_PCHK:   cmd.op = bms_pkg::OP_PKM;
      bms_pkg::S_PK:     cmd.op = bms_pkg::OP_PK;
      bms_pkg::S_PDIV:   cmd.op = bms_pkg::OP_PDIV;
      bms_pkg::S_PNK:    cmd.op = bms_pkg::OP_PNKM;
      bms_pkg::S_PVEL:   cmd.op = bms_pkg::OP_PVEL;
      bms_pkg::S_CNT:    cmd.op = bms_pkg::OP_CNTM;
      bms_pkg::S_CRDIFF: cmd.op = bms_pkg::OP_CRDIFF;
      bms_pkg::S_CRM:    cmd.op = bms_pkg::OP_CRM;
      bms_pkg::S_CROWD:  cmd.op = bms_pkg::OP_CROWD;
      bms_pkg::S_FRM:    cmd.op = bms_pkg::OP_FRM;
      bms_pkg::S_FEAR:   cmd.op = bms_pkg::OP_FEAR;
      bms_pkg::S_ADDACC: cmd.op = bms_pkg::OP_ADDACC;
      bms_pkg::S_VSQ:    cmd.op = bms_pkg::OP_VSQ;
      bms_pkg::S_VACC:   cmd.op = bms_pkg::OP_ACC;
      bms_pkg::S_VSQRT:  cmd.op = bms_pkg::OP_SQRT;
      bms_pkg::S_VDIV:   cmd.op = bms_pkg::OP_VDIV;
      bms_pkg::S_DIR:    cmd.op = bms_pkg::OP_DIR;
      bms_pkg::S_MAXS:   cmd.op = bms_pkg::OP_MAXS;
      bms_pkg::S_MXM:    cmd.op = bms_pkg::OP_MXM;
      bms_pkg::S_MXC:    cmd.op = bms_pkg::OP_MXC;
      bms_pkg::S_MNM:    cmd.op = bms_pkg::OP_MNM;
      bms_pkg::S_MNC:    cmd.op = bms_pkg::OP_MNC;
      bms_pkg::S_CLM:    cmd.op = bms_pkg::OP_CLM;
      bms_pkg::S_CLS:    cmd.op = bms_pkg::OP_CLS;
      bms_pkg::S_FSM:    cmd.op = bms_pkg::OP_FSM;
      bms_pkg::S_FSS:    cmd.op = bms_pkg::OP_FSS;
      bms_pkg::S_POS:    cmd.op = bms_pkg::OP_POS;
      bms_pkg::S_TLM:    cmd.op = bms_pkg::OP_TLM;
      bms_pkg::S_TLS:    cmd.op = bms_pkg::OP_TLS;
      bms_pkg::S_DCM:    cmd.op = bms_pkg::OP_DCM;
      bms_pkg::S_DCS:    cmd.op = bms_pkg::OP_DCS;
      bms_pkg::S_OUT:    if (slot_free) cmd.op = bms_pkg::OP_OUT;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam longint ONE_Q = 64'sd65536;
  localparam longint HALF_Q = 64'sd32768;
  localparam longint K_CROWD_STEP = 64'sd1311;   // 0.02
  localparam longint K_TENTH = 64'sd6554;        // 0.1
  localparam longint K_FIFTH = 64'sd13107;       // 0.2
  localparam longint K_PULL = 64'sd16;           // 0.00025
  localparam longint K_THRESH = 64'sd200 * ONE_Q;
  localparam logic [bms_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 3000;

  class motion_scoreboard;
    logic [31:0] pos[3];
    longint vel[3], ctr[3];
    longint crowd, fear, max_spd, min_spd, decay, body;
    bms_pkg::out_word_t pending[$];
    int mismatches, results_seen;

    function void reset_state();
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0;
        vel[i] = 0;
        ctr[i] = 0;
      end
      crowd = ONE_Q;
      fear = ONE_Q;
      max_spd = 212992;
      min_spd = 81920;
      decay = 64881;
      body = 327680;
    endfunction

    function void set_reg(logic [bms_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        bms_pkg::REG_MAX_SPEED: max_spd = longint'(v[20:0]);
        bms_pkg::REG_MIN_SPEED: min_spd = longint'(v[20:0]);
        bms_pkg::REG_DECAY: decay = longint'(v[15:0]);
        bms_pkg::REG_BODY_LENGTH: body = longint'(v[22:0]);
        bms_pkg::REG_CENTER_X: ctr[0] = longint'($signed(v));
        bms_pkg::REG_CENTER_Y: ctr[1] = longint'($signed(v));
        bms_pkg::REG_CENTER_Z: ctr[2] = longint'($signed(v));
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // floor square root of the sum of squares
    function longint magnitude(longint c[3], output longint unsigned sum_sq);
      longint unsigned s, a, r, b;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        a = (c[i] < 0) ? -c[i] : c[i];
        s += a * a;
      end
      sum_sq = s;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function void note_item(bms_pkg::in_word_t w);
      longint acc[3], dir[3], d[3];
      longint len, k, n, goal, maxs;
      longint unsigned sq;
      bms_pkg::out_word_t e;
      logic [31:0] tail[3];
      acc[0] = w.acc_x;
      acc[1] = w.acc_y;
      acc[2] = w.acc_z;
      if (w.pull_to_center) begin
        for (int i = 0; i < 3; i++) d[i] = clip32(longint'($signed(pos[i])) - ctr[i]);
        len = magnitude(d, sq);
        if (len > K_THRESH) begin
          k = ((len - K_THRESH) * K_PULL) >>> 16;
          for (int i = 0; i < 3; i++) begin
            n = (d[i] * ONE_Q) / len;
            vel[i] = clip32(vel[i] - ((n * k) >>> 16));
          end
        end
      end
      goal = ONE_Q - longint'(w.neighbor_count) * K_CROWD_STEP;
      crowd -= ((crowd - goal) * K_TENTH) >>> 16;
      if (crowd < HALF_Q) crowd = HALF_Q;
      if (crowd > ONE_Q) crowd = ONE_Q;
      fear -= (fear * K_FIFTH) >>> 16;
      if (w.flatten) acc[2] = 0;
      for (int i = 0; i < 3; i++) vel[i] = clip32(vel[i] + acc[i]);
      len = magnitude(vel, sq);
      for (int i = 0; i < 3; i++) dir[i] = (len != 0) ? (vel[i] * ONE_Q) / len : 0;
      maxs = max_spd + crowd;
      if (sq > longint'(maxs * maxs)) begin
        for (int i = 0; i < 3; i++) vel[i] = (dir[i] * maxs) >>> 16;
      end else if (sq < longint'(min_spd * min_spd)) begin
        for (int i = 0; i < 3; i++) vel[i] = (dir[i] * min_spd) >>> 16;
      end
      for (int i = 0; i < 3; i++) begin
        vel[i] = clip32((vel[i] * (ONE_Q + fear)) >>> 16);
        pos[i] = pos[i] + vel[i][31:0];
      end
      if (w.flatten) pos[2] = 0;
      for (int i = 0; i < 3; i++) begin
        k = (dir[i] * body) >>> 16;
        tail[i] = pos[i] - k[31:0];
        vel[i] = clip32((vel[i] * decay) >>> 16);
      end
      e.pos_x = pos[0];
      e.pos_y = pos[1];
      e.pos_z = pos[2];
      e.tail_x = tail[0];
      e.tail_y = tail[1];
      e.tail_z = tail[2];
      e.vel_x = vel[0][31:0];
      e.vel_y = vel[1][31:0];
      e.vel_z = vel[2][31:0];
      pending = {pending, e};
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, what);
    endfunction

    function void check_result(bms_pkg::out_word_t got);
      string names[9] = '{"pos_x", "pos_y", "pos_z", "tail_x", "tail_y", "tail_z",
                          "vel_x", "vel_y", "vel_z"};
      bms_pkg::out_word_t exp_w;
      logic [287:0] eb, gb;
      results_seen++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result word %h", got));
        return;
      end
      exp_w = pending.pop_front();
      eb = exp_w;
      gb = got;
      for (int f = 0; f < 9; f++) begin
        if (eb[287 - 32*f -: 32] !== gb[287 - 32*f -: 32])
          flag($sformatf("result %0d %s expected %h got %h", results_seen, names[f],
                         eb[287 - 32*f -: 32], gb[287 - 32*f -: 32]));
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  bms_pkg::in_word_t item = '0;
  logic result_valid;
  logic result_stall = 0;
  bms_pkg::out_word_t result;
  logic cfg_we = 0;
  logic [bms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  motion_scoreboard sb = new();
  bit quiet = 0;
  bit long_hold = 0;
  int cycles = 0;
  int items_sent = 0;

  boid_motion_step DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall pattern
  initial begin
    int len;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        result_stall <= 1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 0;
        long_hold = 0;
        @(posedge clk);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          result_stall <= 1;
          repeat (len) @(posedge clk);
        end
        result_stall <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_word(bms_pkg::in_word_t w);
    int g;
    item_valid <= 1;
    item <= w;
    do @(posedge clk); while (item_stall);
    sb.note_item(w);
    items_sent++;
    g = pick_gap();
    if (g > 0) begin
      item_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    wait (sb.pending.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bms_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic bms_pkg::in_word_t make_word(input logic signed [31:0] ax, ay, az,
                                                  input logic [7:0] cnt, input logic fl, pl);
    bms_pkg::in_word_t w;
    w.acc_x = ax;
    w.acc_y = ay;
    w.acc_z = az;
    w.neighbor_count = cnt;
    w.flatten = fl;
    w.pull_to_center = pl;
    return w;
  endfunction

  function automatic logic [31:0] rand_acc();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 524288) - 262144;
  endfunction

  task automatic random_words(int n, int pull_pct);
    bms_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      quiet = ((i / 30) % 3 == 2);
      w = make_word(rand_acc(), rand_acc(), rand_acc(), $urandom_range(0, 255),
                    $urandom_range(0, 9) == 0, $urandom_range(0, 99) < pull_pct);
      send_word(w);
    end
    quiet = 0;
  endtask

  initial begin
    sb.reset_state();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: zero velocity, extremes, flatten, crowd limits
    send_word(make_word(0, 0, 0, 0, 0, 0));
    send_word(make_word(0, 0, 0, 8'd255, 0, 1));
    send_word(make_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 8'd255, 0, 0));
    send_word(make_word(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0));
    send_word(make_word(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 8'd25, 1, 0));
    send_word(make_word(65536, 0, 0, 8'd50, 0, 1));
    send_word(make_word(0, -65536, 0, 8'd1, 1, 1));
    send_word(make_word(32'sh7fffffff, 0, 0, 8'd128, 0, 1));
    send_word(make_word(32'shffffffff, 1, 32'shffffffff, 8'd127, 0, 0));
    send_word(make_word(0, 0, 0, 8'd200, 1, 0));
    random_words(130, 20);
    drain();

    // wide speeds, far center; far pull from the start
    write_reg(bms_pkg::REG_MAX_SPEED, 32'd1048576);
    write_reg(bms_pkg::REG_MIN_SPEED, 32'd0);
    write_reg(bms_pkg::REG_DECAY, 32'd65535);
    write_reg(bms_pkg::REG_BODY_LENGTH, 32'd4194304);
    write_reg(bms_pkg::REG_CENTER_X, 32'h80000000);
    write_reg(bms_pkg::REG_CENTER_Y, 32'h7fffffff);
    write_reg(bms_pkg::REG_CENTER_Z, 32'h00000000);
    write_reg(REG_UNUSED, 32'hffffffff);
    send_word(make_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 1));
    send_word(make_word(32'sh80000000, 32'sh7fffffff, 0, 0, 0, 1));
    send_word(make_word(0, 0, 0, 8'd255, 1, 1));
    random_words(140, 60);
    drain();

    // zero top speed, min above max, no decay, no body
    write_reg(bms_pkg::REG_MAX_SPEED, 32'd0);
    write_reg(bms_pkg::REG_MIN_SPEED, 32'd1048576);
    write_reg(bms_pkg::REG_DECAY, 32'd0);
    write_reg(bms_pkg::REG_BODY_LENGTH, 32'd0);
    write_reg(bms_pkg::REG_CENTER_X, 32'h7fffffff);
    write_reg(bms_pkg::REG_CENTER_Y, 32'h80000000);
    write_reg(bms_pkg::REG_CENTER_Z, 32'h80000000);
    random_words(140, 40);
    drain();

    // random settings
    write_reg(bms_pkg::REG_MAX_SPEED, $urandom_range(0, 1048576));
    write_reg(bms_pkg::REG_MIN_SPEED, $urandom_range(0, 400000));
    write_reg(bms_pkg::REG_DECAY, $urandom_range(0, 65535));
    write_reg(bms_pkg::REG_BODY_LENGTH, $urandom_range(0, 4194304));
    write_reg(bms_pkg::REG_CENTER_X, $urandom);
    write_reg(bms_pkg::REG_CENTER_Y, $urandom);
    write_reg(bms_pkg::REG_CENTER_Z, $urandom);
    random_words(140, 50);
    drain();

    // back to defaults; long receiver hold, then sender waits out the pipe
    write_reg(bms_pkg::REG_MAX_SPEED, 32'd212992);
    write_reg(bms_pkg::REG_MIN_SPEED, 32'd81920);
    write_reg(bms_pkg::REG_DECAY, 32'd64881);
    write_reg(bms_pkg::REG_BODY_LENGTH, 32'd327680);
    write_reg(bms_pkg::REG_CENTER_X, 32'd0);
    write_reg(bms_pkg::REG_CENTER_Y, 32'd0);
    write_reg(bms_pkg::REG_CENTER_Z, 32'd0);
    long_hold = 1;
    random_words(70, 30);
    item_valid <= 0;
    @(posedge clk);
    wait (sb.pending.size() == 0);
    random_words(70, 30);
    drain();

    $display("%0d words through 5 register settings, directed extremes, pull and flatten,",
             items_sent);
    $display("random gaps on both sides and a %0d cycle output hold", LONG_HOLD);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
